FILE: src/value_noise_texel_generator_top_defines.svh
// Assertion macros for the value noise texel generator.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef VALUE_NOISE_TEXEL_GENERATOR_TOP_DEFINES_SVH
`define VALUE_NOISE_TEXEL_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VNTG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vntg check failed");
`define VNTG_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("vntg check failed");
`else
`define VNTG_ASSERT(label, prop)
`define VNTG_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: src/vntg_pkg.sv
// Package for the value noise texel generator: widths, register map, hash constants, types.
// No dependencies.
`default_nettype none
package vntg_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int PIX_W      = 12;
    localparam int REG_W      = 24;
    localparam int STEP_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = COORD_BITS + STEP_W;
    localparam int CELL_W     = POS_W - FRAC_BITS;
    localparam int HASH_W     = 32;
    localparam int NOISE_W    = 16;
    localparam int NOISE_LSB  = 15;
    localparam int CHAN_W     = 8;
    localparam int HASH_SHIFT = 13;

    localparam logic [CFG_IDX_W-1:0] REG_X_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VAR    = 2'd3;

    localparam logic [REG_W-1:0] X_STEP_RST = 24'd6144;
    localparam logic [REG_W-1:0] Y_STEP_RST = 24'd6144;
    localparam logic [REG_W-1:0] BASE_RST   = 24'h827864;
    localparam logic [REG_W-1:0] VAR_RST    = 24'h282828;

    localparam logic [HASH_W-1:0] HASH_K1 = 32'd374761393;
    localparam logic [HASH_W-1:0] HASH_K2 = 32'd668265263;
    localparam logic [HASH_W-1:0] HASH_K3 = 32'd1274126177;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
        logic [REG_W-1:0]  base_rgb;
        logic [REG_W-1:0]  variation_color;
    } cfg_t;

    typedef struct packed {
        logic [HASH_W-1:0]    cell_x;
        logic [HASH_W-1:0]    cell_y;
        logic [FRAC_BITS-1:0] frac_x;
        logic [FRAC_BITS-1:0] frac_y;
    } pos_t;

    typedef struct packed {
        logic [NOISE_W-1:0]   n00;
        logic [NOISE_W-1:0]   n10;
        logic [NOISE_W-1:0]   n01;
        logic [NOISE_W-1:0]   n11;
        logic [FRAC_BITS-1:0] frac_x;
        logic [FRAC_BITS-1:0] frac_y;
    } corners_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } texel_t;

    // pipeline stage control: advance enable and incoming valid
    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

    function automatic logic [HASH_W-1:0] hash_mix(input logic [HASH_W-1:0] h);
        return h ^ (h >> HASH_SHIFT);
    endfunction

endpackage
`default_nettype wire

FILE: src/vntg_if.sv
// Handshake channels of the value noise texel generator: coordinate in, texel out.
// Depends on vntg_pkg.
`default_nettype none
interface vntg_coord_if;
    logic                        valid;
    logic                        ready;
    logic [vntg_pkg::PIX_W-1:0]  pixel_x;
    logic [vntg_pkg::PIX_W-1:0]  pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface vntg_texel_if;
    logic                        valid;
    logic                        ready;
    logic [vntg_pkg::CHAN_W-1:0] red;
    logic [vntg_pkg::CHAN_W-1:0] green;
    logic [vntg_pkg::CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

FILE: src/vntg_cfg_regs.sv
// Configuration register bank: steps and colours, written through a plain write port.
// Depends on vntg_pkg.
`default_nettype none
module vntg_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vntg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vntg_pkg::REG_W-1:0]     cfg_data,
    output vntg_pkg::cfg_t                 cfg
);
    import vntg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_X_STEP: cfg_next.x_step          = cfg_data;
                REG_Y_STEP: cfg_next.y_step          = cfg_data;
                REG_BASE:   cfg_next.base_rgb        = cfg_data;
                REG_VAR:    cfg_next.variation_color = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_step          <= X_STEP_RST;
            cfg_reg.y_step          <= Y_STEP_RST;
            cfg_reg.base_rgb        <= BASE_RST;
            cfg_reg.variation_color <= VAR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: src/vntg_scale.sv
// Coordinate scaling stage: coordinate times lattice step, split into cell and fraction.
// Depends on vntg_pkg.
`default_nettype none
module vntg_scale (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vntg_pkg::stage_ctl_t       ctl,
    input  logic [vntg_pkg::PIX_W-1:0] pixel_x,
    input  logic [vntg_pkg::PIX_W-1:0] pixel_y,
    input  logic [vntg_pkg::STEP_W-1:0] x_step,
    input  logic [vntg_pkg::STEP_W-1:0] y_step,
    output logic                       out_valid,
    output vntg_pkg::pos_t             pos
);
    import vntg_pkg::*;

    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [POS_W-1:0]      prod_x;
    logic [POS_W-1:0]      prod_y;
    pos_t                  pos_next;
    pos_t                  pos_reg;
    logic                  valid_reg;

    always_comb
    begin
        coord_x  = COORD_BITS'(pixel_x);
        coord_y  = COORD_BITS'(pixel_y);
        prod_x   = POS_W'(coord_x) * POS_W'(x_step);
        prod_y   = POS_W'(coord_y) * POS_W'(y_step);
        pos_next.cell_x = HASH_W'(prod_x[POS_W-1:FRAC_BITS]);
        pos_next.cell_y = HASH_W'(prod_y[POS_W-1:FRAC_BITS]);
        pos_next.frac_x = prod_x[FRAC_BITS-1:0];
        pos_next.frac_y = prod_y[FRAC_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.en)
            valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            pos_reg <= pos_next;
    end

    assign out_valid = valid_reg;
    assign pos       = pos_reg;

endmodule
`default_nettype wire

FILE: src/vntg_hash.sv
// Corner hash pipeline: three stages (multiply, add and xor-shift, multiply) for four corners.
// Depends on vntg_pkg.
`default_nettype none
module vntg_hash (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vntg_pkg::stage_ctl_t ctl,
    input  vntg_pkg::pos_t       pos,
    output logic                 out_valid,
    output vntg_pkg::corners_t   corners
);
    import vntg_pkg::*;

    logic [2:0]           valid_reg;

    logic [HASH_W-1:0]    mx_reg;
    logic [HASH_W-1:0]    my_reg;
    logic [FRAC_BITS-1:0] fx1_reg;
    logic [FRAC_BITS-1:0] fy1_reg;

    logic [HASH_W-1:0]    mix_next [4];
    logic [HASH_W-1:0]    mix_reg  [4];
    logic [FRAC_BITS-1:0] fx2_reg;
    logic [FRAC_BITS-1:0] fy2_reg;

    logic [HASH_W-1:0]    prod3    [4];
    corners_t             corners_next;
    corners_t             corners_reg;

    logic [HASH_W-1:0]    mx_next;
    logic [HASH_W-1:0]    my_next;
    logic [HASH_W-1:0]    mx1;
    logic [HASH_W-1:0]    my1;

    // corner order: 00, 10, 01, 11; +1 on a cell folds into +K on the product
    always_comb
    begin
        mx_next = pos.cell_x * HASH_K1;
        my_next = pos.cell_y * HASH_K2;
        mx1     = mx_reg + HASH_K1;
        my1     = my_reg + HASH_K2;
        mix_next[0] = hash_mix(mx_reg + my_reg);
        mix_next[1] = hash_mix(mx1 + my_reg);
        mix_next[2] = hash_mix(mx_reg + my1);
        mix_next[3] = hash_mix(mx1 + my1);
        for (int i = 0; i < 4; i++)
            prod3[i] = mix_reg[i] * HASH_K3;
        corners_next.n00    = prod3[0][NOISE_LSB+NOISE_W-1:NOISE_LSB];
        corners_next.n10    = prod3[1][NOISE_LSB+NOISE_W-1:NOISE_LSB];
        corners_next.n01    = prod3[2][NOISE_LSB+NOISE_W-1:NOISE_LSB];
        corners_next.n11    = prod3[3][NOISE_LSB+NOISE_W-1:NOISE_LSB];
        corners_next.frac_x = fx2_reg;
        corners_next.frac_y = fy2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ctl.en)
            valid_reg <= {valid_reg[1:0], ctl.valid};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            mx_reg      <= mx_next;
            my_reg      <= my_next;
            fx1_reg     <= pos.frac_x;
            fy1_reg     <= pos.frac_y;
            mix_reg     <= mix_next;
            fx2_reg     <= fx1_reg;
            fy2_reg     <= fy1_reg;
            corners_reg <= corners_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign corners   = corners_reg;

endmodule
`default_nettype wire

FILE: src/vntg_blend.sv
// Bilinear blend pipeline: four stages, lerp on x for both rows, then lerp on y.
// Depends on vntg_pkg and value_noise_texel_generator_top_defines.svh.
`default_nettype none
`include "value_noise_texel_generator_top_defines.svh"
module vntg_blend (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vntg_pkg::stage_ctl_t        ctl,
    input  vntg_pkg::corners_t          corners,
    output logic                        out_valid,
    output logic [vntg_pkg::NOISE_W-1:0] noise
);
    import vntg_pkg::*;

    localparam int DIFF_W = NOISE_W + 1;
    localparam int LP_W   = NOISE_W + FRAC_BITS + 2;

    logic                     en;
    logic signed [LP_W-1:0]   fx_s;
    logic signed [LP_W-1:0]   fy_s;
    logic signed [LP_W-1:0]   dtop_s;
    logic signed [LP_W-1:0]   dbot_s;
    logic signed [LP_W-1:0]   dy_s;
    logic signed [LP_W-1:0]   sh_top;
    logic signed [LP_W-1:0]   sh_bot;
    logic signed [LP_W-1:0]   sh_y;
    logic signed [DIFF_W-1:0] diff_top;
    logic signed [DIFF_W-1:0] diff_bot;
    logic signed [DIFF_W-1:0] diff_y;

    logic                     a_valid_reg;
    logic [NOISE_W-1:0]       a_n00_reg;
    logic [NOISE_W-1:0]       a_n01_reg;
    logic signed [LP_W-1:0]   a_ptop_reg;
    logic signed [LP_W-1:0]   a_pbot_reg;
    logic [FRAC_BITS-1:0]     a_fy_reg;

    logic                     b_valid_reg;
    logic [NOISE_W-1:0]       b_top_reg;
    logic [NOISE_W-1:0]       b_bot_reg;
    logic [FRAC_BITS-1:0]     b_fy_reg;

    logic                     c_valid_reg;
    logic [NOISE_W-1:0]       c_top_reg;
    logic signed [LP_W-1:0]   c_prod_reg;

    logic                     d_valid_reg;
    logic [NOISE_W-1:0]       d_noise_reg;

    logic signed [LP_W-1:0]   a_ptop_next;
    logic signed [LP_W-1:0]   a_pbot_next;
    logic [NOISE_W-1:0]       b_top_next;
    logic [NOISE_W-1:0]       b_bot_next;
    logic signed [LP_W-1:0]   c_prod_next;
    logic [NOISE_W-1:0]       d_noise_next;

    assign en = ctl.en;

    // lo + floor((hi - lo) * f / 2^F) equals the two-product form exactly
    always_comb
    begin
        diff_top    = $signed({1'b0, corners.n10}) - $signed({1'b0, corners.n00});
        diff_bot    = $signed({1'b0, corners.n11}) - $signed({1'b0, corners.n01});
        fx_s        = $signed(LP_W'(corners.frac_x));
        dtop_s      = LP_W'(diff_top);
        dbot_s      = LP_W'(diff_bot);
        a_ptop_next = dtop_s * fx_s;
        a_pbot_next = dbot_s * fx_s;

        sh_top      = a_ptop_reg >>> FRAC_BITS;
        sh_bot      = a_pbot_reg >>> FRAC_BITS;
        b_top_next  = a_n00_reg + sh_top[NOISE_W-1:0];
        b_bot_next  = a_n01_reg + sh_bot[NOISE_W-1:0];

        diff_y      = $signed({1'b0, b_bot_reg}) - $signed({1'b0, b_top_reg});
        dy_s        = LP_W'(diff_y);
        fy_s        = $signed(LP_W'(b_fy_reg));
        c_prod_next = dy_s * fy_s;

        sh_y         = c_prod_reg >>> FRAC_BITS;
        d_noise_next = c_top_reg + sh_y[NOISE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= ctl.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_n00_reg   <= corners.n00;
            a_n01_reg   <= corners.n01;
            a_ptop_reg  <= a_ptop_next;
            a_pbot_reg  <= a_pbot_next;
            a_fy_reg    <= corners.frac_y;
            b_top_reg   <= b_top_next;
            b_bot_reg   <= b_bot_next;
            b_fy_reg    <= a_fy_reg;
            c_top_reg   <= b_top_reg;
            c_prod_reg  <= c_prod_next;
            d_noise_reg <= d_noise_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign noise     = d_noise_reg;

    `VNTG_ASSERT(a_flat_row_no_slope, (en && b_valid_reg && ((b_top_reg == b_bot_reg) || (b_fy_reg == '0))) |=> (c_prod_reg == '0))
    `VNTG_ASSERT(a_valid_moves, (en && a_valid_reg) |=> b_valid_reg)
    `VNTG_ASSERT(a_stall_holds, (!en && d_valid_reg) |=> (d_valid_reg && $stable(d_noise_reg)))

endmodule
`default_nettype wire

FILE: src/vntg_shade.sv
// Colour stage: base plus variation times (2n - 1) per channel, clamped; holds the output item.
// Depends on vntg_pkg.
`default_nettype none
module vntg_shade (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vntg_pkg::stage_ctl_t         ctl,
    input  logic [vntg_pkg::NOISE_W-1:0] noise,
    input  logic [vntg_pkg::REG_W-1:0]   base_rgb,
    input  logic [vntg_pkg::REG_W-1:0]   variation_color,
    output logic                         out_valid,
    output vntg_pkg::texel_t             texel
);
    import vntg_pkg::*;

    localparam int D_W     = NOISE_W + 2;
    localparam int SHADE_W = CHAN_W + NOISE_W + 4;

    function automatic logic [CHAN_W-1:0] shade(
        input logic [CHAN_W-1:0]     base,
        input logic [CHAN_W-1:0]     amp,
        input logic signed [D_W-1:0] d
    );
        logic signed [SHADE_W-1:0] s_base;
        logic signed [SHADE_W-1:0] s_amp;
        logic signed [SHADE_W-1:0] s_d;
        logic signed [SHADE_W-1:0] s;
        s_base = $signed({{(SHADE_W-CHAN_W-NOISE_W){1'b0}}, base, {NOISE_W{1'b0}}});
        s_amp  = $signed(SHADE_W'(amp));
        s_d    = SHADE_W'(d);
        s      = s_base + s_amp * s_d;
        if (s < 0)
            return '0;
        else if (s[SHADE_W-1:NOISE_W] > SHADE_W'(CHAN_MAX))
            return CHAN_MAX;
        else
            return s[NOISE_W+CHAN_W-1:NOISE_W];
    endfunction

    logic signed [D_W-1:0] d;
    texel_t                texel_next;
    texel_t                texel_reg;
    logic                  valid_reg;

    always_comb
    begin
        d = $signed({1'b0, noise, 1'b0}) - $signed({2'b01, {NOISE_W{1'b0}}});
        texel_next.red   = shade(base_rgb[23:16], variation_color[23:16], d);
        texel_next.green = shade(base_rgb[15:8], variation_color[15:8], d);
        texel_next.blue  = shade(base_rgb[7:0], variation_color[7:0], d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.en)
            valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            texel_reg <= texel_next;
    end

    assign out_valid = valid_reg;
    assign texel     = texel_reg;

endmodule
`default_nettype wire

FILE: src/value_noise_texel_generator_top.sv
// Value noise texel generator: one RGB texel of bilinear value noise per pixel coordinate.
// Channels: coord (valid/ready with pixel_x, pixel_y) in, texel (valid/ready with red,
// green, blue) out. Registers x_step, y_step, base_rgb, variation_color are written
// through cfg_we/cfg_index/cfg_data; indexes beyond the list are ignored.
// Throughput: one item per cycle, sustained while the receiver is ready, for any mix of coordinates.
// Pipeline from acceptance to texel valid: scaling multiply, corner hash (multiply, add
// and xor-shift, multiply), bilinear blend, colour and clamp, each stage registered.
// The pipeline depth is set by the two 32-bit hash multiplies and the three lerps.
// Reset clears every stage valid bit and loads the register defaults; no item is held.
// When the receiver stalls, the whole pipeline freezes together with the output item
// and coord.ready drops in the same cycle; nothing is lost or repeated.
// The user must write registers only while no item is in flight; the block does not enforce it.
// Depends on vntg_pkg, vntg_if, vntg_cfg_regs, vntg_scale, vntg_hash, vntg_blend,
// vntg_shade and value_noise_texel_generator_top_defines.svh.
`default_nettype none
`include "value_noise_texel_generator_top_defines.svh"
module value_noise_texel_generator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    vntg_coord_if.sink                     coord,
    vntg_texel_if.source                   texel,
    input  logic                           cfg_we,
    input  logic [vntg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vntg_pkg::REG_W-1:0]     cfg_data
);
    import vntg_pkg::*;

    cfg_t               cfg;
    logic               advance;
    stage_ctl_t         scale_ctl;
    stage_ctl_t         hash_ctl;
    stage_ctl_t         blend_ctl;
    stage_ctl_t         shade_ctl;
    logic               scale_valid;
    logic               hash_valid;
    logic               blend_valid;
    logic               shade_valid;
    pos_t               pos;
    corners_t           corners;
    logic [NOISE_W-1:0] noise;
    texel_t             texel_out;

    assign advance     = !shade_valid || texel.ready;
    assign coord.ready = advance;

    assign scale_ctl = '{en: advance, valid: coord.valid};
    assign hash_ctl  = '{en: advance, valid: scale_valid};
    assign blend_ctl = '{en: advance, valid: hash_valid};
    assign shade_ctl = '{en: advance, valid: blend_valid};

    vntg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vntg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scale_ctl),
        .pixel_x   (coord.pixel_x),
        .pixel_y   (coord.pixel_y),
        .x_step    (cfg.x_step),
        .y_step    (cfg.y_step),
        .out_valid (scale_valid),
        .pos       (pos)
    );

    vntg_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (hash_ctl),
        .pos       (pos),
        .out_valid (hash_valid),
        .corners   (corners)
    );

    vntg_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (blend_ctl),
        .corners   (corners),
        .out_valid (blend_valid),
        .noise     (noise)
    );

    vntg_shade u_shade (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (shade_ctl),
        .noise           (noise),
        .base_rgb        (cfg.base_rgb),
        .variation_color (cfg.variation_color),
        .out_valid       (shade_valid),
        .texel           (texel_out)
    );

    assign texel.valid = shade_valid;
    assign texel.red   = texel_out.red;
    assign texel.green = texel_out.green;
    assign texel.blue  = texel_out.blue;

    `VNTG_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !shade_valid)
    `VNTG_ASSERT(a_taken_advances, (texel.valid && texel.ready) |-> coord.ready)
    `VNTG_ASSERT(a_stall_freezes_out, (shade_valid && !texel.ready) |=> ($stable(texel_out) && shade_valid))

endmodule
`default_nettype wire
